// ----- rtl/blfb_pkg.sv -----
// shared types and constants for the bresenham line framebuffer unit
package blfb_pkg;

  // default framebuffer size in bytes
  localparam int FB_BYTES_DEF = 1024;

  // field and register widths
  localparam int COORD_W    = 7;
  localparam int CNT_W      = 8;
  localparam int DIM_W      = 8;
  localparam int BC_W       = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  // full pixel byte address before range check, and its compare width
  localparam int PADDR_W    = 13;
  localparam int PCMP_W     = PADDR_W + 1;
  // bresenham decision term width (signed)
  localparam int ERR_W      = 10;
  localparam int PROD_W     = 2 * DIM_W;

  // reset values of the configuration registers
  localparam logic            LAYOUT_RST = 1'b0;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 8'd128;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 8'd64;
  localparam logic [BC_W-1:0]  BYTES_RST  = 11'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES  = 3'd3;

  // command codes
  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_ERASE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SETUP1,
    S_SETUP2,
    S_RD,
    S_WR,
    S_PIX,
    S_CLRMUL,
    S_CLRLIM,
    S_CLR,
    S_DONE
  } state_t;

endpackage

// ----- rtl/blfb_ram.sv -----
// generic single-write, single-read ram with registered read data
module blfb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bresenham_line_framebuffer_unit.sv -----
// bresenham line rasterizer over a 1-bit-per-pixel framebuffer
//
// in_* carries one command request (draw line, erase line, read pixel,
// clear image); out_* returns exactly one result per command with the read
// pixel bit and the number of pixel positions stepped by a line. cfg_* writes
// the layout, width, height and byte count registers and is always ready.
// A single sequencer with one address unit and one byte-wide ram does
// all the work, one command at a time; in_tready is high only when idle.
// Line: setup states SETUP1 and SETUP2, then per pixel a ram read and a
// write back of the modified byte, for |major delta|+1 pixels, before the
// result is loaded into the output register. Read pixel passes SETUP1, RD
// and PIX. Clear passes SETUP1, CLRMUL and CLRLIM, then zeroes one byte per
// cycle ((width*height)/8 bytes, capped at FB_BYTES). in_tready returns in
// the cycle after the result is loaded. After reset a clearing pass writes
// zero to every byte with in_tready low; config writes are taken.
// The result sits in an output register; if the receiver stalls, a next
// command is still accepted and processed, and it waits in its final state
// until the output register is free.
module bresenham_line_framebuffer_unit
  import blfb_pkg::*;
#(
  parameter int FB_BYTES = FB_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // x_start[6:0], y_start[13:7], x_end[20:14], y_end[27:21]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  // pixel_value[0], pixels_written[8:1]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(FB_BYTES);

  state_t state_r, state_nxt;

  // configuration registers
  logic              layout_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [BC_W-1:0]   bytes_r;

  // command registers
  op_t               op_r;
  logic [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;

  // line walk registers
  logic [COORD_W-1:0] adx_r, ady_r;
  logic               xmaj_r;
  logic [COORD_W-1:0] maj_r, min_r;
  logic [COORD_W-1:0] majd_r, mind_r;
  logic               neg_r;
  logic signed [ERR_W-1:0] d_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   n_r;
  logic               pix_r;

  // pixel access registers
  logic [AW-1:0]      addr_r;
  logic [2:0]         bit_r;
  logic               ok_r;

  // clear registers
  logic [PROD_W-1:0]  prod_r;
  logic [AW:0]        lim_r;
  logic [AW-1:0]      idx_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // ram connections
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic in_req, out_load;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_req     = in_tvalid && in_tready;

  // configuration writes, low bits kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= LAYOUT_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      bytes_r  <= BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYOUT: layout_r <= cfg_data[0];
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_BYTES:  bytes_r  <= cfg_data[BC_W-1:0];
        default: ;
      endcase
    end
  end

  // current pixel coordinates
  logic [COORD_W-1:0] cur_x, cur_y;
  assign cur_x = xmaj_r ? maj_r : min_r;
  assign cur_y = xmaj_r ? min_r : maj_r;

  // shared pixel address unit
  logic [PADDR_W-1:0] paddr;
  logic [2:0]         pbit;
  logic               pok;
  always_comb begin
    if (!layout_r) begin
      pbit  = cur_y[2:0];
      paddr = PADDR_W'(cur_y[COORD_W-1:3]) * PADDR_W'(width_r) + PADDR_W'(cur_x);
    end else begin
      pbit  = cur_x[2:0];
      paddr = PADDR_W'(cur_x[COORD_W-1:3]) * PADDR_W'(height_r) + PADDR_W'(cur_y);
    end
    pok = (PCMP_W'(paddr) < PCMP_W'(bytes_r)) && (PCMP_W'(paddr) < PCMP_W'(FB_BYTES));
  end

  // setup arithmetic
  logic               swap;
  logic [COORD_W-1:0] sx0, sy0, sx1, sy1, majd, mind;
  logic [PADDR_W-1:0] clr_lim;
  always_comb begin
    swap = xmaj_r ? (x1_r < x0_r) : (y1_r < y0_r);
    sx0  = swap ? x1_r : x0_r;
    sy0  = swap ? y1_r : y0_r;
    sx1  = swap ? x0_r : x1_r;
    sy1  = swap ? y0_r : y1_r;
    majd = xmaj_r ? adx_r : ady_r;
    mind = xmaj_r ? ady_r : adx_r;
    clr_lim = prod_r[PROD_W-1:3];
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and ram controls
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = 8'h00;
    out_load  = 1'b0;
    case (state_r)
      S_INIT: begin
        ram_we = 1'b1;
        if (idx_r == AW'(FB_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_SETUP1;
        end
      end
      S_SETUP1: begin
        case (op_r)
          OP_READ:  state_nxt = S_RD;
          OP_CLEAR: state_nxt = S_CLRMUL;
          default:  state_nxt = S_SETUP2;
        endcase
      end
      S_SETUP2: state_nxt = S_RD;
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = (op_r == OP_READ) ? S_PIX : S_WR;
      end
      S_WR: begin
        ram_we    = ok_r;
        ram_waddr = addr_r;
        ram_wdata = (op_r == OP_ERASE) ? (ram_rdata & ~(8'h01 << bit_r))
                                       : (ram_rdata | (8'h01 << bit_r));
        state_nxt = (cnt_r == '0) ? S_DONE : S_RD;
      end
      S_PIX:    state_nxt = S_DONE;
      S_CLRMUL: state_nxt = S_CLRLIM;
      S_CLRLIM: state_nxt = (clr_lim == '0) ? S_DONE : S_CLR;
      S_CLR: begin
        ram_we = 1'b1;
        if ((AW + 1)'(idx_r) + (AW + 1)'(1) == lim_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // byte index for clearing passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (state_r == S_INIT || state_r == S_CLR) begin
      idx_r <= idx_r + AW'(1);
    end else if (state_r == S_CLRLIM) begin
      idx_r <= '0;
    end
  end

  // command capture and line walk datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_req) begin
          op_r <= op_t'(in_tuser);
          x0_r <= in_tdata[6:0];
          y0_r <= in_tdata[13:7];
          x1_r <= in_tdata[20:14];
          y1_r <= in_tdata[27:21];
        end
      end
      S_SETUP1: begin
        n_r   <= '0;
        pix_r <= 1'b0;
        cnt_r <= '0;
        adx_r <= (x1_r >= x0_r) ? x1_r - x0_r : x0_r - x1_r;
        ady_r <= (y1_r >= y0_r) ? y1_r - y0_r : y0_r - y1_r;
        if (op_r == OP_READ) begin
          xmaj_r <= 1'b1;
          maj_r  <= x0_r;
          min_r  <= y0_r;
        end else begin
          xmaj_r <= ((y1_r >= y0_r) ? y1_r - y0_r : y0_r - y1_r) <
                    ((x1_r >= x0_r) ? x1_r - x0_r : x0_r - x1_r);
        end
        prod_r <= PROD_W'(width_r) * PROD_W'(height_r);
      end
      S_SETUP2: begin
        maj_r  <= xmaj_r ? sx0 : sy0;
        min_r  <= xmaj_r ? sy0 : sx0;
        neg_r  <= xmaj_r ? (sy1 < sy0) : (sx1 < sx0);
        majd_r <= majd;
        mind_r <= mind;
        d_r    <= $signed({2'b00, mind, 1'b0}) - $signed({3'b000, majd});
        cnt_r  <= CNT_W'(majd) + CNT_W'(1);
        n_r    <= CNT_W'(majd) + CNT_W'(1);
      end
      S_RD: begin
        // latch address, then take one bresenham step
        addr_r <= paddr[AW-1:0];
        bit_r  <= pbit;
        ok_r   <= pok;
        if (op_r != OP_READ) begin
          maj_r <= maj_r + COORD_W'(1);
          cnt_r <= cnt_r - CNT_W'(1);
          if (d_r > 0) begin
            min_r <= neg_r ? min_r - COORD_W'(1) : min_r + COORD_W'(1);
            d_r   <= d_r + $signed({2'b00, mind_r, 1'b0}) - $signed({2'b00, majd_r, 1'b0});
          end else begin
            d_r   <= d_r + $signed({2'b00, mind_r, 1'b0});
          end
        end
      end
      S_PIX: pix_r <= ok_r & ram_rdata[bit_r];
      S_CLRLIM: begin
        lim_r <= (PCMP_W'(clr_lim) >= PCMP_W'(FB_BYTES)) ? (AW + 1)'(FB_BYTES)
                                                          : (AW + 1)'(clr_lim);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{(OUT_DATA_W - CNT_W - 1){1'b0}}, n_r, pix_r};
    end
  end

  // framebuffer store
  blfb_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(paddr[AW-1:0]),
    .rdata(ram_rdata)
  );

  // a new result appears only from the final state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result raised outside final state");

  // an accepted request always enters setup next
  a_req_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_req |=> state_r == S_SETUP1)
    else $error("accepted request did not start setup");

  // a line never walks more than 128 pixel positions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> cnt_r < 8'd128)
    else $error("pixel counter out of range");

  // ram writes happen only in clearing or write-back states
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INIT || state_r == S_CLR || state_r == S_WR))
    else $error("ram write outside write states");

endmodule
